>>> sv/mpd_pkg.sv
// Shared constants, codes and the result record for the mesh packet deframer.
package mpd_pkg;

  localparam int ADDR_BYTES        = 16;
  localparam int MAX_PACKET_BYTES  = 500;
  localparam int MAX_PAYLOAD_BYTES = 465;

  localparam int CNT_W = 10;               // packet byte position, saturates
  localparam int LEN_W = CNT_W + 1;        // packet length, up to 1024
  localparam int OFF_W = 9;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // flags, hops, destination address, context byte; type two adds a transport address
  localparam int MIN_LEN_ONE = 2 + ADDR_BYTES + 1;
  localparam int MIN_LEN_TWO = MIN_LEN_ONE + ADDR_BYTES;

  typedef enum logic [2:0] {
    FK_FLAGS     = 3'd0,
    FK_HOPS      = 3'd1,
    FK_TRANSPORT = 3'd2,
    FK_DEST      = 3'd3,
    FK_CONTEXT   = 3'd4,
    FK_PAYLOAD   = 3'd5
  } field_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_AUTH     = 2'd2
  } status_t;

  typedef struct packed {
    field_kind_t       field_kind;
    logic [OFF_W-1:0]  field_offset;
    logic [7:0]        data;
    logic              hdr_type_two;
    logic              ctx_flag;
    logic              via_transport;
    logic [1:0]        dest_kind;
    logic [1:0]        pkt_kind;
    logic              done_res;
    status_t           status;
    logic [OFF_W-1:0]  payload_length;
  } mpd_res_t;

endpackage

>>> sv/mesh_packet_deframer.sv
// Mesh packet deframer: one received byte in, one classified byte out.
// Each byte passes through the input register and then the result register, where out_valid is raised.
// Throughput: one byte per cycle while out_stall is low; parser state advances as a byte enters the result register.
// in_stall follows out_stall only while both registers hold a transaction.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to byte 0.
module mesh_packet_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_field_kind,
  output logic [8:0] out_field_offset,
  output logic [7:0] out_byte,
  output logic       out_hdr_type_two,
  output logic       out_ctx_flag,
  output logic       out_via_transport,
  output logic [1:0] out_dest_kind,
  output logic [1:0] out_pkt_kind,
  output logic       out_done_res,
  output logic [1:0] out_status,
  output logic [8:0] out_payload_length
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [7:0]        s1_byte_r;
  logic              s1_last_r;
  logic              out_valid_r, out_valid_nxt;
  mpd_pkg::mpd_res_t res, res_r;
  logic              out_free, adv, in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  mpd_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .byte_i (s1_byte_r),
    .last_i (s1_last_r),
    .res    (res)
  );

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_free ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
    if (adv) res_r <= res;
  end

  assign out_valid          = out_valid_r;
  assign out_field_kind     = res_r.field_kind;
  assign out_field_offset   = res_r.field_offset;
  assign out_byte           = res_r.data;
  assign out_hdr_type_two   = res_r.hdr_type_two;
  assign out_ctx_flag       = res_r.ctx_flag;
  assign out_via_transport  = res_r.via_transport;
  assign out_dest_kind      = res_r.dest_kind;
  assign out_pkt_kind       = res_r.pkt_kind;
  assign out_done_res       = res_r.done_res;
  assign out_status         = res_r.status;
  assign out_payload_length = res_r.payload_length;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced transaction lost before result register");

endmodule

>>> sv/mpd_parse.sv
// Packet position tracking, field classification and end-of-packet checks.
module mpd_parse (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,       // current byte moves to the result register
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  output mpd_pkg::mpd_res_t res
);

  logic [mpd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]                flags_r, flags_nxt;
  logic                      overlong_r, overlong_nxt;

  logic [7:0]                flags;
  logic                      two;
  logic [mpd_pkg::CNT_W-1:0] q, q2, pay_off;
  logic [mpd_pkg::LEN_W-1:0] len, hdr, plen;
  logic                      too_long;

  always_comb begin
    flags   = (cnt_r == '0) ? byte_i : flags_r;
    two     = flags[6];
    q       = cnt_r - mpd_pkg::CNT_W'(2);
    q2      = two ? q - mpd_pkg::CNT_W'(mpd_pkg::ADDR_BYTES) : q;
    pay_off = q2 - mpd_pkg::CNT_W'(mpd_pkg::ADDR_BYTES + 1);

    res = '0;
    res.data          = byte_i;
    res.hdr_type_two  = flags[6];
    res.ctx_flag      = flags[5];
    res.via_transport = flags[4];
    res.dest_kind     = flags[3:2];
    res.pkt_kind      = flags[1:0];
    res.done_res      = last_i;
    res.status        = mpd_pkg::ST_OK;

    if (cnt_r == '0) begin
      res.field_kind = mpd_pkg::FK_FLAGS;
    end else if (cnt_r == mpd_pkg::CNT_W'(1)) begin
      res.field_kind = mpd_pkg::FK_HOPS;
    end else if (two && q < mpd_pkg::CNT_W'(mpd_pkg::ADDR_BYTES)) begin
      res.field_kind   = mpd_pkg::FK_TRANSPORT;
      res.field_offset = q[mpd_pkg::OFF_W-1:0];
    end else if (q2 < mpd_pkg::CNT_W'(mpd_pkg::ADDR_BYTES)) begin
      res.field_kind   = mpd_pkg::FK_DEST;
      res.field_offset = q2[mpd_pkg::OFF_W-1:0];
    end else if (q2 == mpd_pkg::CNT_W'(mpd_pkg::ADDR_BYTES)) begin
      res.field_kind = mpd_pkg::FK_CONTEXT;
    end else begin
      res.field_kind   = mpd_pkg::FK_PAYLOAD;
      res.field_offset = pay_off[mpd_pkg::OFF_W-1:0];
    end

    // end-of-packet checks, in priority order
    len      = {1'b0, cnt_r} + mpd_pkg::LEN_W'(1);
    hdr      = two ? mpd_pkg::LEN_W'(mpd_pkg::MIN_LEN_TWO)
                   : mpd_pkg::LEN_W'(mpd_pkg::MIN_LEN_ONE);
    plen     = len - hdr;
    too_long = overlong_r || (len > mpd_pkg::LEN_W'(mpd_pkg::MAX_PACKET_BYTES));
    if (last_i) begin
      if (too_long || len < mpd_pkg::LEN_W'(mpd_pkg::MIN_LEN_ONE)) begin
        res.status = mpd_pkg::ST_BAD_SIZE;
      end else if (flags[7]) begin
        res.status = mpd_pkg::ST_AUTH;
      end else if (len < hdr) begin
        res.status = mpd_pkg::ST_BAD_SIZE;
      end else if (plen > mpd_pkg::LEN_W'(mpd_pkg::MAX_PAYLOAD_BYTES)) begin
        res.status = mpd_pkg::ST_BAD_SIZE;
      end else if (plen > mpd_pkg::LEN_W'(511)) begin
        res.payload_length = '1;
      end else begin
        res.payload_length = plen[mpd_pkg::OFF_W-1:0];
      end
    end
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    flags_nxt    = flags_r;
    overlong_nxt = overlong_r;
    if (adv) begin
      if (last_i) begin
        cnt_nxt      = '0;
        flags_nxt    = '0;
        overlong_nxt = 1'b0;
      end else begin
        if (cnt_r == '0) flags_nxt = byte_i;
        if (cnt_r >= mpd_pkg::CNT_W'(mpd_pkg::MAX_PACKET_BYTES)) overlong_nxt = 1'b1;
        cnt_nxt = (cnt_r == mpd_pkg::CNT_MAX) ? cnt_r : cnt_r + mpd_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      flags_r    <= '0;
      overlong_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      flags_r    <= flags_nxt;
      overlong_r <= overlong_nxt;
    end
  end

  a_eop_restart: assert property (@(posedge clk) disable iff (!rst_n)
    adv && last_i |=> cnt_r == '0 && flags_r == '0 && !overlong_r)
    else $error("parser state not cleared after last byte");

  a_fail_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    res.status != mpd_pkg::ST_OK |-> res.payload_length == '0 && res.done_res)
    else $error("failed packet reports a payload length");

  a_overlong_pos: assert property (@(posedge clk) disable iff (!rst_n)
    overlong_r |-> cnt_r > mpd_pkg::CNT_W'(mpd_pkg::MAX_PACKET_BYTES))
    else $error("overlong set at a short position");

  a_flags_first: assert property (@(posedge clk) disable iff (!rst_n)
    (res.field_kind == mpd_pkg::FK_FLAGS) == (cnt_r == '0))
    else $error("flags field away from packet start");

endmodule
